### sv/rsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the RPN stack machine.
// Depends on nothing; the files that use it refer to it by scoped names.
package rsm_pkg;

    // Item kinds carried in the func field.
    localparam logic [2:0] FUNC_PUSH   = 3'd0;
    localparam logic [2:0] FUNC_ADD    = 3'd1;
    localparam logic [2:0] FUNC_ASSIGN = 3'd2;
    localparam logic [2:0] FUNC_INVERT = 3'd3;
    localparam logic [2:0] FUNC_OR     = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_NOREG = 2'd3;

    // Reset value of the operator enable mask: all four operators registered.
    localparam logic [3:0] MASK_RESET = 4'hF;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the word, apply clear, issue the operand read
        logic commit;  // execute, update the stack and load the result register
    } dp_cmd_t;

endpackage

### sv/rsm_item_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input words and result words.
// Depends on nothing.
interface rsm_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] push_value;
    logic               clear_first;

    modport source (output valid, output func, output push_value, output clear_first,
                    input ready);
    modport sink   (input valid, input func, input push_value, input clear_first,
                    output ready);
endinterface

interface rsm_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic [6:0]         stack_count;
    logic [1:0]         status;

    modport source (output valid, output top_value, output stack_count, output status,
                    input ready);
    modport sink   (input valid, input top_value, input stack_count, input status,
                    output ready);
endinterface

### sv/rsm_ctrl.sv
`timescale 1ns / 1ps
// Controller for the RPN stack machine: accepts words, sequences execution
// and owns the result valid flag. Depends on rsm_pkg.
module rsm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output rsm_pkg::dp_cmd_t cmd
);

    rsm_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    // The result register can take a new word when it is empty or the old one is leaving.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        case (state_reg)
            rsm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rsm_pkg::S_EXEC;
                end
            end
            rsm_pkg::S_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rsm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rsm_pkg::S_IDLE;
            end
        endcase
    end

    // State and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/rsm_datapath.sv
`timescale 1ns / 1ps
// Datapath for the RPN stack machine: stack memory, cached top of stack,
// stack pointer, enable mask and result register. Depends on rsm_pkg.
module rsm_datapath
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rsm_pkg::dp_cmd_t   cmd,
    input  logic [2:0]         func,
    input  logic signed [31:0] push_value,
    input  logic               clear_first,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    output logic signed [31:0] top_value,
    output logic [6:0]         stack_count,
    output logic [1:0]         status
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
    localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

    // Stack storage; the top entry is also mirrored in top_reg.
    logic [31:0]    stack_mem [STACK_DEPTH];

    logic [3:0]     mask_reg;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [31:0]    top_reg;
    logic [31:0]    second_reg;
    logic [2:0]     func_reg;
    logic [31:0]    value_reg;

    logic [31:0]    res_top_reg;
    logic [6:0]     res_count_reg;
    logic [1:0]     res_status_reg;

    logic [SPW-1:0] sp_eff;
    logic [SPW-1:0] rd_ptr;
    logic [AW-1:0]  rd_addr;
    logic           need_two;
    logic           op_enabled;
    logic [1:0]     exec_status;
    logic [31:0]    exec_result;
    logic [SPW-1:0] wr_ptr;
    logic [AW-1:0]  wr_addr;
    logic           exec_ok;

    // Clear applies before the word runs; the second operand sits two below.
    assign sp_eff  = clear_first ? '0 : sp_reg;
    assign rd_ptr  = sp_eff - SP_TWO;
    assign rd_addr = rd_ptr[AW-1:0];

    // Operator registration check.
    always_comb
    begin
        case (func_reg)
            rsm_pkg::FUNC_ADD:    op_enabled = mask_reg[0];
            rsm_pkg::FUNC_ASSIGN: op_enabled = mask_reg[1];
            rsm_pkg::FUNC_INVERT: op_enabled = mask_reg[2];
            rsm_pkg::FUNC_OR:     op_enabled = mask_reg[3];
            default:              op_enabled = 1'b0;
        endcase
    end

    assign need_two = (func_reg == rsm_pkg::FUNC_ADD) || (func_reg == rsm_pkg::FUNC_OR);

    // Status of the word: disabled is checked ahead of underflow.
    always_comb
    begin
        if (func_reg == rsm_pkg::FUNC_PUSH)
        begin
            exec_status = (sp_reg >= SP_FULL) ? rsm_pkg::ST_OVER : rsm_pkg::ST_OK;
        end
        else if (!op_enabled)
        begin
            exec_status = rsm_pkg::ST_NOREG;
        end
        else if (need_two ? (sp_reg < SP_TWO) : (sp_reg < SP_ONE))
        begin
            exec_status = rsm_pkg::ST_UNDER;
        end
        else
        begin
            exec_status = rsm_pkg::ST_OK;
        end
    end

    assign exec_ok = (exec_status == rsm_pkg::ST_OK);

    // Operation result, new pointer and write position of the new top.
    always_comb
    begin
        case (func_reg)
            rsm_pkg::FUNC_PUSH:
            begin
                exec_result = value_reg;
                sp_next     = sp_reg + SP_ONE;
                wr_ptr      = sp_reg;
            end
            rsm_pkg::FUNC_ADD:
            begin
                exec_result = second_reg + top_reg;
                sp_next     = sp_reg - SP_ONE;
                wr_ptr      = sp_reg - SP_TWO;
            end
            rsm_pkg::FUNC_INVERT:
            begin
                exec_result = ~top_reg;
                sp_next     = sp_reg;
                wr_ptr      = sp_reg - SP_ONE;
            end
            rsm_pkg::FUNC_OR:
            begin
                exec_result = second_reg | top_reg;
                sp_next     = sp_reg - SP_ONE;
                wr_ptr      = sp_reg - SP_TWO;
            end
            default:
            begin
                exec_result = top_reg;
                sp_next     = sp_reg;
                wr_ptr      = sp_reg - SP_ONE;
            end
        endcase
    end

    assign wr_addr = wr_ptr[AW-1:0];

    // Stack memory: operand read on load, new top written on a successful commit.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            second_reg <= stack_mem[rd_addr];
        end
        if (cmd.commit && exec_ok)
        begin
            stack_mem[wr_addr] <= exec_result;
        end
    end

    // Latched word, cached top and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= push_value;
        end
        if (cmd.commit)
        begin
            if (exec_ok)
            begin
                top_reg        <= exec_result;
                res_top_reg    <= exec_result;
                res_count_reg  <= 7'(sp_next);
            end
            else
            begin
                res_top_reg    <= (sp_reg != '0) ? top_reg : '0;
                res_count_reg  <= 7'(sp_reg);
            end
            res_status_reg <= exec_status;
        end
    end

    // Stack pointer and enable mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            mask_reg <= rsm_pkg::MASK_RESET;
        end
        else
        begin
            if (cmd.load)
            begin
                sp_reg <= sp_eff;
            end
            else if (cmd.commit && exec_ok)
            begin
                sp_reg <= sp_next;
            end
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
        end
    end

    assign top_value   = res_top_reg;
    assign stack_count = res_count_reg;
    assign status      = res_status_reg;

endmodule

### sv/rpn_stack_machine_core.sv
`timescale 1ns / 1ps
// Top level of the RPN stack machine: controller plus datapath.
// Depends on rsm_pkg, rsm_item_if, rsm_result_if, rsm_ctrl and rsm_datapath.
//
//  Channel   Dir  Handshake            Word contents
//  cmd       in   valid / ready        func, push_value, clear_first
//  rsp       out  valid / ready        top_value, stack_count, status
//  cfg       in   cfg_wr_en            cfg_wr_data (op_enable_mask)
//
// Each word is accepted in S_IDLE, where the second operand is read from the
// stack memory, whose read port is registered, and is then executed in S_EXEC.
// The top of stack is held in a register, so only binary operators use the read.
// rst_n clears the stack pointer, the controller and the enable mask (all on).
// A word is accepted while the previous result still waits; execution holds
// only while the result register is full and rsp.ready is low.
module rpn_stack_machine_core
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    rsm_item_if.sink     cmd,
    rsm_result_if.source rsp,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data
);

    rsm_pkg::dp_cmd_t dp_cmd;

    // Sequencing of accept, execute and result hand-off.
    rsm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (dp_cmd)
    );

    // Stack, operators and result register.
    rsm_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .func        (cmd.func),
        .push_value  (cmd.push_value),
        .clear_first (cmd.clear_first),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .top_value   (rsp.top_value),
        .stack_count (rsp.stack_count),
        .status      (rsp.status)
    );

endmodule

### sv/rsm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the RPN stack machine, bound to the top level.
// Depends on rsm_pkg and rpn_stack_machine_core.
module rsm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [6:0] rsp_count,
    input logic [1:0] rsp_status
);

    // A stalled result word stays offered, with its status and count unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
        else $error("result word changed while stalled");

    // Once a word is taken, the next one waits for execution.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("word accepted while another is executing");

    // Underflow can only be reported with fewer than two entries.
    a_underflow_depth: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == rsm_pkg::ST_UNDER) |-> rsp_count < 7'd2)
        else $error("underflow reported with enough operands");

    // A successful word always leaves at least one entry.
    a_ok_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == rsm_pkg::ST_OK) |-> rsp_count != 7'd0)
        else $error("successful word left an empty stack");

endmodule

bind rpn_stack_machine_core rsm_checker u_rsm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_count  (rsp.stack_count),
    .rsp_status (rsp.status)
);
